[rtl/plm_pkg.sv]
package plm_pkg;

   // List geometry
   localparam int CAPACITY = 64;
   localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam int CNT_W    = $clog2(CAPACITY + 1);
   localparam int POS_W    = 8;
   localparam int CMP_W    = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;
   localparam int LEN_W    = 7;
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int STAT_W   = 3;

   // Operation codes
   localparam logic [OP_W-1:0] OP_INS_HEAD = 3'd0;
   localparam logic [OP_W-1:0] OP_INS_TAIL = 3'd1;
   localparam logic [OP_W-1:0] OP_INS_POS  = 3'd2;
   localparam logic [OP_W-1:0] OP_DEL_HEAD = 3'd3;
   localparam logic [OP_W-1:0] OP_DEL_TAIL = 3'd4;
   localparam logic [OP_W-1:0] OP_DEL_POS  = 3'd5;
   localparam logic [OP_W-1:0] OP_SEARCH   = 3'd6;

   // Status codes
   localparam logic [STAT_W-1:0] ST_OK     = 3'd0;
   localparam logic [STAT_W-1:0] ST_EMPTY  = 3'd1;
   localparam logic [STAT_W-1:0] ST_BADPOS = 3'd2;
   localparam logic [STAT_W-1:0] ST_RANGE  = 3'd3;
   localparam logic [STAT_W-1:0] ST_FULL   = 3'd4;
   localparam logic [STAT_W-1:0] ST_MISS   = 3'd5;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      logic                     ins;
      logic                     del;
      logic [IDX_W-1:0]         idx;
      logic [CNT_W-1:0]         cnt;
      logic signed [DATA_W-1:0] data;
   } cell_cmd_type;

   // Sequencer states
   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_EXEC = 2'b10
   } state_type;

endpackage

[rtl/plm_req_if.sv]
interface plm_req_if;
   import plm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [OP_W-1:0]          operation;
   logic signed [DATA_W-1:0] value;
   logic [POS_W-1:0]         position;

   modport source (output valid, output operation, output value, output position,
                   input ready);
   modport sink   (input valid, input operation, input value, input position,
                   output ready);
endinterface

[rtl/plm_rsp_if.sv]
interface plm_rsp_if;
   import plm_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [STAT_W-1:0]        status;
   logic signed [DATA_W-1:0] removed_value;
   logic [LEN_W-1:0]         length;

   modport source (output valid, output status, output removed_value, output length,
                   input ready);
   modport sink   (input valid, input status, input removed_value, input length,
                   output ready);
endinterface

[rtl/plm_cell.sv]
module plm_cell (
   input  logic                             clock,
   input  plm_pkg::cell_cmd_type            cmd,
   input  logic [plm_pkg::IDX_W-1:0]        cell_index,
   input  logic signed [plm_pkg::DATA_W-1:0] left_value,
   input  logic signed [plm_pkg::DATA_W-1:0] right_value,
   output logic signed [plm_pkg::DATA_W-1:0] value_out,
   output logic                             match,
   output logic signed [plm_pkg::DATA_W-1:0] pick
);
   import plm_pkg::*;

   logic signed [DATA_W-1:0] value_ff;
   logic signed [DATA_W-1:0] value_in;
   logic                     live;
   logic                     at_idx;
   logic                     past_idx;

   assign live     = CNT_W'(cell_index) < cmd.cnt;
   assign at_idx   = cell_index == cmd.idx;
   assign past_idx = cell_index > cmd.idx;

   // Shift toward the tail on insert, toward the head on delete
   always_comb begin
      value_in = value_ff;
      if (cmd.ins) begin
         if (at_idx) begin
            value_in = cmd.data;
         end else if (past_idx) begin
            value_in = left_value;
         end
      end else if (cmd.del) begin
         if (at_idx || past_idx) begin
            value_in = right_value;
         end
      end
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;
   assign match     = live && (value_ff == cmd.data);
   assign pick      = at_idx ? value_ff : '0;

endmodule

[rtl/positional_ordered_list_core.sv]
// Channel   Port      Dir  Item
// --------  --------  ---  ---------------------------------------------
// request   req_port  in   operation[3], value[32] signed, position[8]
// response  rsp_port  out  status[3], removed_value[32] signed, length[7]
//
// Each item passes an accept state that latches it, then an execute state
// in which every cell of the chain shifts or compares in parallel and the
// result is loaded into the response register. The response register lets
// the next item be accepted while a result waits; an item stays in its
// execute state while the response register is full and not taken. Reset
// (synchronous) empties the list; cell contents are not cleared.
module positional_ordered_list_core (
   input  logic       clock,
   input  logic       reset,
   plm_req_if.sink    req_port,
   plm_rsp_if.source  rsp_port
);
   import plm_pkg::*;

   state_type state_ff, state_in;

   // Latched item
   logic [OP_W-1:0]          op_ff;
   logic signed [DATA_W-1:0] val_ff;
   logic [POS_W-1:0]         pos_ff;

   logic [CNT_W-1:0]         count_ff, count_in;

   // Response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [STAT_W-1:0]        status_ff, status_in;
   logic signed [DATA_W-1:0] removed_ff, removed_in;

   cell_cmd_type             cmd;
   logic                     go;
   logic                     do_ins, do_del;
   logic [CMP_W-1:0]         idx_wide;
   logic [CMP_W-1:0]         cnt_wide;
   logic [CMP_W-1:0]         pos_wide;
   logic                     empty, full;
   logic                     any_match;
   logic signed [DATA_W-1:0] picked;

   logic signed [DATA_W-1:0] cell_value [CAPACITY];
   logic signed [DATA_W-1:0] cell_pick  [CAPACITY];
   logic [CAPACITY-1:0]      cell_match;

   assign req_port.ready = state_ff == S_IDLE;
   assign go = (state_ff == S_EXEC) && (!rsp_valid_ff || rsp_port.ready);

   assign cnt_wide = CMP_W'(count_ff);
   assign pos_wide = CMP_W'(pos_ff);
   assign empty    = count_ff == '0;
   assign full     = count_ff == CNT_W'(CAPACITY);

   // Decode the latched item into status and a cell command
   always_comb begin
      status_in = ST_OK;
      do_ins    = 1'b0;
      do_del    = 1'b0;
      idx_wide  = '0;
      unique case (op_ff)
         OP_INS_HEAD: begin
            if (full) status_in = ST_FULL;
            else do_ins = 1'b1;
         end
         OP_INS_TAIL: begin
            idx_wide = cnt_wide;
            if (full) status_in = ST_FULL;
            else do_ins = 1'b1;
         end
         OP_INS_POS: begin
            idx_wide = pos_wide - CMP_W'(1);
            if (pos_ff == '0) status_in = ST_BADPOS;
            else if (pos_wide > cnt_wide + CMP_W'(1)) status_in = ST_RANGE;
            else if (full) status_in = ST_FULL;
            else do_ins = 1'b1;
         end
         OP_DEL_HEAD: begin
            if (empty) status_in = ST_EMPTY;
            else do_del = 1'b1;
         end
         OP_DEL_TAIL: begin
            idx_wide = cnt_wide - CMP_W'(1);
            if (empty) status_in = ST_EMPTY;
            else do_del = 1'b1;
         end
         OP_DEL_POS: begin
            idx_wide = pos_wide - CMP_W'(1);
            if (empty) status_in = ST_EMPTY;
            else if (pos_ff == '0) status_in = ST_BADPOS;
            else if (pos_wide > cnt_wide) status_in = ST_RANGE;
            else do_del = 1'b1;
         end
         OP_SEARCH: begin
            if (empty) status_in = ST_EMPTY;
            else if (!any_match) status_in = ST_MISS;
         end
         default: begin
            status_in = ST_OK;
         end
      endcase
   end

   assign cmd.ins  = go && do_ins;
   assign cmd.del  = go && do_del;
   assign cmd.idx  = idx_wide[IDX_W-1:0];
   assign cmd.cnt  = count_ff;
   assign cmd.data = val_ff;

   // Cell chain
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DATA_W-1:0] left_v, right_v;
      if (i == 0) begin : g_first
         assign left_v = '0;
      end else begin : g_mid_l
         assign left_v = cell_value[i-1];
      end
      if (i == CAPACITY - 1) begin : g_last
         assign right_v = '0;
      end else begin : g_mid_r
         assign right_v = cell_value[i+1];
      end
      plm_cell u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .cell_index  (IDX_W'(i)),
         .left_value  (left_v),
         .right_value (right_v),
         .value_out   (cell_value[i]),
         .match       (cell_match[i]),
         .pick        (cell_pick[i])
      );
   end

   // Reduce the per-cell outputs
   always_comb begin
      picked = '0;
      for (int k = 0; k < CAPACITY; k++) begin
         picked = picked | cell_pick[k];
      end
   end
   assign any_match  = |cell_match;
   assign removed_in = do_del ? picked : '0;

   // Sequencer and count
   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_port.ready;
      unique case (state_ff)
         S_IDLE: begin
            if (req_port.valid) state_in = S_EXEC;
         end
         S_EXEC: begin
            if (go) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (do_ins) count_in = count_ff + CNT_W'(1);
               else if (do_del) count_in = count_ff - CNT_W'(1);
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (req_port.valid && req_port.ready) begin
         op_ff  <= req_port.operation;
         val_ff <= req_port.value;
         pos_ff <= req_port.position;
      end
      if (go) begin
         status_ff  <= status_in;
         removed_ff <= removed_in;
      end
   end

   assign rsp_port.valid         = rsp_valid_ff;
   assign rsp_port.status        = status_ff;
   assign rsp_port.removed_value = removed_ff;
   assign rsp_port.length        = LEN_W'(count_ff);

endmodule

[test/testbench.sv]
module testbench;
   import plm_pkg::*;

   // Unused operation code: the block must ignore it
   localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;

   localparam int TOTAL_ITEMS  = 850;
   localparam int STALL_LIMIT  = 1000;
   localparam int HOLD_CYCLES  = 60;
   localparam int DRAIN_CYCLES = 10;
   localparam int PLAN_ROWS    = 24;

   typedef struct packed {
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] removed;
      logic [LEN_W-1:0]         length;
   } list_rsp_type;

   // One directed row: request fields, then the result where it is typed in
   typedef struct packed {
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] value;
      logic [POS_W-1:0]         pos;
      logic                     typed;
      logic [STAT_W-1:0]        status;
      logic signed [DATA_W-1:0] removed;
      logic [LEN_W-1:0]         length;
   } list_step_type;

   typedef enum logic [1:0] {
      SEG_GROW,
      SEG_SHRINK,
      SEG_MIXED
   } seg_mode_type;

   logic clock;
   logic reset;

   plm_req_if req_bus();
   plm_rsp_if rsp_bus();

   positional_ordered_list_core u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus)
   );

   // Shadow copy of the list and the results still owed by the block
   logic signed [DATA_W-1:0] model_list[$];
   list_rsp_type             due_results[$];
   list_rsp_type             typed_rsp;
   logic                     use_typed;
   list_step_type            directed_plan [PLAN_ROWS];
   int                       error_count;
   int                       idle_cycles;
   int                       items_sent;
   logic                     hold_rsp;

   // Clock
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Insert into the shadow list, refusing when full
   function automatic logic [STAT_W-1:0] insert_entry(int idx, logic signed [DATA_W-1:0] v);
      if (model_list.size() >= CAPACITY)
         return ST_FULL;
      model_list.insert(idx, v);
      return ST_OK;
   endfunction

   // Apply one request to the shadow list and return the result it gives
   function automatic list_rsp_type apply_list_op(logic [OP_W-1:0] op,
                                                  logic signed [DATA_W-1:0] val,
                                                  logic [POS_W-1:0] pos);
      list_rsp_type r;
      int           n;
      int           p;
      r = '0;
      n = model_list.size();
      p = int'(pos);
      case (op)
         OP_INS_HEAD: r.status = insert_entry(0, val);
         OP_INS_TAIL: r.status = insert_entry(n, val);
         OP_INS_POS: begin
            if (p == 0)
               r.status = ST_BADPOS;
            else if (p > n + 1)
               r.status = ST_RANGE;
            else
               r.status = insert_entry(p - 1, val);
         end
         OP_DEL_HEAD: begin
            if (n == 0)
               r.status = ST_EMPTY;
            else
               r.removed = model_list.pop_front();
         end
         OP_DEL_TAIL: begin
            if (n == 0)
               r.status = ST_EMPTY;
            else
               r.removed = model_list.pop_back();
         end
         OP_DEL_POS: begin
            if (n == 0)
               r.status = ST_EMPTY;
            else if (p == 0)
               r.status = ST_BADPOS;
            else if (p > n)
               r.status = ST_RANGE;
            else begin
               r.removed = model_list[p - 1];
               model_list.delete(p - 1);
            end
         end
         OP_SEARCH: begin
            if (n == 0)
               r.status = ST_EMPTY;
            else begin
               r.status = ST_MISS;
               foreach (model_list[k])
                  if (model_list[k] == val)
                     r.status = ST_OK;
            end
         end
         default: ;
      endcase
      r.length = LEN_W'(model_list.size());
      return r;
   endfunction

   // Idle length: mostly none, some short, a few long
   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Half extremes and small values (duplicates help search), half anything
   function automatic logic signed [DATA_W-1:0] rand_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return -32'sd1;
         3: return 32'sd0;
         4: return $urandom_range(0, 15);
         default: return $urandom;
      endcase
   endfunction

   // Mostly a legal position in 1..lim, sometimes zero or anything
   function automatic logic [POS_W-1:0] pick_position(int lim);
      int r;
      r = $urandom_range(0, 99);
      if (r < 80 && lim > 0)
         return POS_W'($urandom_range(1, lim));
      if (r < 88)
         return '0;
      return POS_W'($urandom_range(0, 255));
   endfunction

   // Offer one item after an optional gap and wait until it is taken
   task automatic send_item(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] val,
                            input logic [POS_W-1:0] pos, input logic typed,
                            input list_rsp_type want, input int gap);
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.valid     <= 1'b1;
      req_bus.operation <= op;
      req_bus.value     <= val;
      req_bus.position  <= pos;
      use_typed = typed;
      typed_rsp = want;
      do @(posedge clock); while (!(req_bus.valid && req_bus.ready));
      items_sent++;
      @(negedge clock);
   endtask

   // A run of random items biased toward growing, shrinking or neither
   task automatic run_segment(input seg_mode_type mode, input int n_items, input logic quick);
      int                       k;
      int                       r;
      int                       n;
      int                       ins_lim;
      int                       del_lim;
      logic [OP_W-1:0]          op;
      logic signed [DATA_W-1:0] val;
      logic [POS_W-1:0]         pos;
      case (mode)
         SEG_GROW:   begin ins_lim = 70; del_lim = 82; end
         SEG_SHRINK: begin ins_lim = 12; del_lim = 80; end
         default:    begin ins_lim = 40; del_lim = 75; end
      endcase
      for (k = 0; k < n_items; k++) begin
         n = model_list.size();
         r = $urandom_range(0, 99);
         if (r < ins_lim)
            case ($urandom_range(0, 2))
               0: op = OP_INS_HEAD;
               1: op = OP_INS_TAIL;
               default: op = OP_INS_POS;
            endcase
         else if (r < del_lim)
            case ($urandom_range(0, 2))
               0: op = OP_DEL_HEAD;
               1: op = OP_DEL_TAIL;
               default: op = OP_DEL_POS;
            endcase
         else if (r < 97)
            op = OP_SEARCH;
         else
            op = OP_UNUSED;
         val = rand_value();
         pos = POS_W'($urandom_range(0, 255));
         if (op == OP_INS_POS)
            pos = pick_position(n + 1);
         else if (op == OP_DEL_POS)
            pos = pick_position(n);
         else if (op == OP_SEARCH && n > 0 && $urandom_range(0, 1) == 1)
            val = model_list[$urandom_range(0, n - 1)];
         send_item(op, val, pos, 1'b0, '0, quick ? 0 : gap_len());
      end
   endtask

   // Compare one result field by field
   function automatic void check_result(list_rsp_type want, list_rsp_type got);
      if (got.status !== want.status) begin
         $error("status: expected %0d, got %0d", want.status, got.status);
         error_count++;
      end
      if (got.removed !== want.removed) begin
         $error("removed_value: expected %0d, got %0d", want.removed, got.removed);
         error_count++;
      end
      if (got.length !== want.length) begin
         $error("length: expected %0d, got %0d", want.length, got.length);
         error_count++;
      end
   endfunction

   // Monitor both channels at the rising edge
   always @(posedge clock) begin
      list_rsp_type pred;
      list_rsp_type got;
      logic         moved;
      moved = 1'b0;
      if (!reset) begin
         if (req_bus.valid && req_bus.ready) begin
            pred = apply_list_op(req_bus.operation, req_bus.value, req_bus.position);
            due_results.push_back(use_typed ? typed_rsp : pred);
            moved = 1'b1;
         end
         if (rsp_bus.valid && rsp_bus.ready) begin
            got.status  = rsp_bus.status;
            got.removed = rsp_bus.removed_value;
            got.length  = rsp_bus.length;
            if (due_results.size() == 0) begin
               $error("result with none expected: status %0d", got.status);
               error_count++;
            end else
               check_result(due_results.pop_front(), got);
            moved = 1'b1;
         end
         if (moved)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
   end

   // Watchdog on cycles with no item moving on either side
   initial begin
      while (idle_cycles < STALL_LIMIT)
         @(posedge clock);
      $display("Test completed with failures");
      $finish;
   end

   // Result side: random stalls, quiet stretches, and one long hold on request
   initial begin
      int stall_left;
      int quiet_left;
      stall_left    = 0;
      quiet_left    = 0;
      rsp_bus.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_rsp) begin
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_rsp = 1'b0;
         end else if (stall_left > 0) begin
            rsp_bus.ready <= 1'b0;
            stall_left--;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (quiet_left > 0)
               quiet_left--;
            else if ($urandom_range(0, 99) < 4)
               quiet_left = $urandom_range(20, 80);
            else if ($urandom_range(0, 99) < 25)
               stall_left = gap_len();
         end
      end
   end

   // Request side and run control
   initial begin
      int           i;
      int           seg;
      list_rsp_type want;
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_INS_HEAD;
      req_bus.value     = '0;
      req_bus.position  = '0;
      use_typed         = 1'b0;
      typed_rsp         = '0;
      hold_rsp          = 1'b0;
      error_count       = 0;
      idle_cycles       = 0;
      items_sent        = 0;

      // Empty-list errors, position errors, extremes, ignored code, then drain
      directed_plan = '{
         '{OP_SEARCH,   32'sd0,         8'd0,   1'b1, ST_EMPTY,  32'sd0, 7'd0},
         '{OP_DEL_HEAD, 32'sd0,         8'd0,   1'b1, ST_EMPTY,  32'sd0, 7'd0},
         '{OP_DEL_TAIL, 32'sd0,         8'd0,   1'b1, ST_EMPTY,  32'sd0, 7'd0},
         '{OP_DEL_POS,  32'sd0,         8'd0,   1'b1, ST_EMPTY,  32'sd0, 7'd0},
         '{OP_INS_POS,  32'sd1,         8'd0,   1'b1, ST_BADPOS, 32'sd0, 7'd0},
         '{OP_INS_POS,  32'sd1,         8'd2,   1'b1, ST_RANGE,  32'sd0, 7'd0},
         '{OP_INS_POS,  32'h8000_0000,  8'd1,   1'b1, ST_OK,     32'sd0, 7'd1},
         '{OP_INS_HEAD, 32'h7fff_ffff,  8'd0,   1'b1, ST_OK,     32'sd0, 7'd2},
         '{OP_INS_TAIL, -32'sd1,        8'd0,   1'b1, ST_OK,     32'sd0, 7'd3},
         '{OP_INS_POS,  32'sd0,         8'd4,   1'b1, ST_OK,     32'sd0, 7'd4},
         '{OP_INS_POS,  32'sd5,         8'd255, 1'b1, ST_RANGE,  32'sd0, 7'd4},
         '{OP_INS_POS,  32'h5a5a_5a5a,  8'd3,   1'b0, ST_OK,     32'sd0, 7'd0},
         '{OP_SEARCH,   32'h5a5a_5a5a,  8'd0,   1'b0, ST_OK,     32'sd0, 7'd0},
         '{OP_SEARCH,   32'h1234_5678,  8'd0,   1'b0, ST_OK,     32'sd0, 7'd0},
         '{OP_UNUSED,   -32'sd1,        8'd255, 1'b1, ST_OK,     32'sd0, 7'd5},
         '{OP_DEL_POS,  32'sd0,         8'd0,   1'b1, ST_BADPOS, 32'sd0, 7'd5},
         '{OP_DEL_POS,  32'sd0,         8'd6,   1'b1, ST_RANGE,  32'sd0, 7'd5},
         '{OP_DEL_POS,  32'sd0,         8'd255, 1'b1, ST_RANGE,  32'sd0, 7'd5},
         '{OP_DEL_POS,  32'sd0,         8'd2,   1'b0, ST_OK,     32'sd0, 7'd0},
         '{OP_DEL_HEAD, 32'sd0,         8'd0,   1'b0, ST_OK,     32'sd0, 7'd0},
         '{OP_DEL_TAIL, 32'sd0,         8'd0,   1'b0, ST_OK,     32'sd0, 7'd0},
         '{OP_DEL_POS,  32'sd0,         8'd2,   1'b0, ST_OK,     32'sd0, 7'd0},
         '{OP_DEL_TAIL, 32'sd0,         8'd0,   1'b0, ST_OK,     32'sd0, 7'd0},
         '{OP_SEARCH,   32'sd0,         8'd0,   1'b1, ST_EMPTY,  32'sd0, 7'd0}
      };

      repeat (7) @(negedge clock);
      reset <= 1'b0;

      for (i = 0; i < PLAN_ROWS; i++) begin
         want.status  = directed_plan[i].status;
         want.removed = directed_plan[i].removed;
         want.length  = directed_plan[i].length;
         send_item(directed_plan[i].op, directed_plan[i].value, directed_plan[i].pos,
                   directed_plan[i].typed, want, gap_len());
      end

      // Grow the list while results are held back, then shrink it
      hold_rsp = 1'b1;
      run_segment(SEG_GROW, 100, 1'b1);
      run_segment(SEG_SHRINK, 90, 1'b0);

      seg = 0;
      while (items_sent < TOTAL_ITEMS) begin
         // Once mid-run, stop offering until every result is back
         if (seg == 5) begin
            req_bus.valid <= 1'b0;
            do @(negedge clock); while (due_results.size() != 0);
         end
         run_segment(seg_mode_type'($urandom_range(0, 2)), $urandom_range(15, 60),
                     $urandom_range(0, 3) == 0);
         seg++;
      end

      req_bus.valid <= 1'b0;
      do @(negedge clock); while (due_results.size() != 0);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
